>>> sv/pss_pkg.sv
// Package for the polygon simplicity sweep: constants, control types, helpers.
package pss_pkg;

  localparam int MaxVerticesDefault = 256;
  localparam int CoordBitsDefault   = 16;

  // Sign of a cross product coded in two bits.
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // Control from the sequencer to the cross-product unit.
  typedef struct packed {
    logic start;
  } cross_ctl_t;

  // Product of two signs is positive when both are nonzero and equal.
  function automatic logic sign_prod_pos(input logic [1:0] a, input logic [1:0] b);
    sign_prod_pos = (a != SIGN_ZERO) && (b != SIGN_ZERO) && (a == b);
  endfunction

endpackage

>>> sv/polygon_simplicity_sweep.sv
// Top level of the polygon simplicity sweep: loader, event sort and sweep sequencer.
//
//   channel  | handshake          | payload
//   vertex   | start, busy        | vertex_x, vertex_y, last_vertex
//   result   | done (one cycle)   | is_simple, overflow
//
// A vertex without last_vertex is taken while busy stays low.
// The closing vertex starts the test: an insertion sort of 2n events
// (up to about 2*n*n compares, each fetching four vertices) and a sweep
// over a sorted active list, where each cross product holds the shared unit.
// The one coordinate RAM port sets the pace.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
module polygon_simplicity_sweep #(
  parameter int MAX_VERTICES = pss_pkg::MaxVerticesDefault,
  parameter int COORD_BITS   = pss_pkg::CoordBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         done,
  output logic                         is_simple,
  output logic                         overflow
);
  import pss_pkg::*;

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int EB = VB + 1;
  localparam int CB = $clog2(MAX_VERTICES + 1);
  localparam int NB = $clog2(2 * MAX_VERTICES + 1);

  // Sequencer state codes.
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_SI     = 6'd1;   // sort outer loop
  localparam logic [5:0] S_SJ     = 6'd2;   // read event_order[j-1]
  localparam logic [5:0] S_SJW    = 6'd3;
  localparam logic [5:0] S_EVB    = 6'd4;   // compute ev_before(v, w)
  localparam logic [5:0] S_SPUT   = 6'd5;
  localparam logic [5:0] S_WI     = 6'd6;   // sweep: read event
  localparam logic [5:0] S_WIW    = 6'd7;
  localparam logic [5:0] S_WEV    = 6'd8;
  localparam logic [5:0] S_LP     = 6'd9;   // left: scan for place
  localparam logic [5:0] S_LPW    = 6'd10;
  localparam logic [5:0] S_LBL    = 6'd11;  // below(e, t)
  localparam logic [5:0] S_LSH    = 6'd12;  // shift up
  localparam logic [5:0] S_LSHW   = 6'd13;
  localparam logic [5:0] S_LINS   = 6'd14;
  localparam logic [5:0] S_LN1    = 6'd15;  // read neighbor above
  localparam logic [5:0] S_LN1W   = 6'd16;
  localparam logic [5:0] S_LST1   = 6'd17;
  localparam logic [5:0] S_LN0    = 6'd18;
  localparam logic [5:0] S_LN0W   = 6'd19;
  localparam logic [5:0] S_LST0   = 6'd20;
  localparam logic [5:0] S_RP     = 6'd21;  // right: search edge
  localparam logic [5:0] S_RPW    = 6'd22;
  localparam logic [5:0] S_RA     = 6'd23;
  localparam logic [5:0] S_RAW    = 6'd24;
  localparam logic [5:0] S_RB     = 6'd25;
  localparam logic [5:0] S_RBW    = 6'd26;
  localparam logic [5:0] S_RST    = 6'd27;
  localparam logic [5:0] S_RSH    = 6'd28;  // shift down
  localparam logic [5:0] S_RSHW   = 6'd29;
  localparam logic [5:0] S_DONE   = 6'd30;
  localparam logic [5:0] S_FETCH  = 6'd31;  // coordinate fetch subroutine
  localparam logic [5:0] S_FWAIT  = 6'd32;
  localparam logic [5:0] S_FGET   = 6'd33;
  localparam logic [5:0] S_XWAIT  = 6'd34;  // cross unit wait

  // Subroutine codes for the evaluation engine.
  localparam logic [1:0] OP_EVB = 2'd0;
  localparam logic [1:0] OP_BLW = 2'd1;
  localparam logic [1:0] OP_STR = 2'd2;

  logic [5:0] state, ret_state;

  logic [CB-1:0] vcount;
  logic          ovf;
  logic [CB-1:0] n;

  // Coordinate memories.
  logic               v_we;
  logic [VB-1:0]      v_addr;
  logic [COORD_BITS-1:0] vx_rd, vy_rd;
  logic [COORD_BITS-1:0] vx_wd, vy_wd;

  pss_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_vx (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(vx_wd), .rdata(vx_rd)
  );
  pss_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_vy (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(vy_wd), .rdata(vy_rd)
  );

  // Event order and active list memories.
  logic          eo_we;
  logic [EB-1:0] eo_addr;
  logic [EB-1:0] eo_wd, eo_rd;
  pss_ram #(.WIDTH(EB), .DEPTH(2 * MAX_VERTICES)) u_eo (
    .clk(clk), .we(eo_we), .addr(eo_addr), .wdata(eo_wd), .rdata(eo_rd)
  );

  logic          al_we;
  logic [VB-1:0] al_addr;
  logic [VB-1:0] al_wd, al_rd;
  pss_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_al (
    .clk(clk), .we(al_we), .addr(al_addr), .wdata(al_wd), .rdata(al_rd)
  );

  // Fetch list: eight vertex index slots, of which four are loaded into a coordinate file.
  logic [VB-1:0]         fidx [8];
  logic signed [COORD_BITS-1:0] fx [8];
  logic signed [COORD_BITS-1:0] fy [8];
  logic [2:0]            fptr;

  // Sort and sweep registers.
  logic [NB-1:0] si, sj, ne;
  logic [EB-1:0] sv_ev, sw_ev;
  logic [CB-1:0] acount, p, k;
  logic [VB-1:0] cur_e, nb_a, nb_b;
  logic [1:0]    op;
  logic [2:0]    step;
  logic          res_bool;
  logic [1:0]    s0, s1;
  logic          result_simple;

  // Cross unit.
  cross_ctl_t cx_ctl;
  logic [2:0] cx_a, cx_b, cx_c;
  logic       cx_done;
  logic [1:0] cx_sgn;

  pss_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .rst(rst), .ctl(cx_ctl),
    .x0(fx[cx_a]), .y0(fy[cx_a]),
    .x1(fx[cx_b]), .y1(fy[cx_b]),
    .x2(fx[cx_c]), .y2(fy[cx_c]),
    .done(cx_done), .sgn(cx_sgn)
  );

  function automatic logic [VB-1:0] succ_f(input logic [VB-1:0] i, input logic [CB-1:0] nn);
    succ_f = ((CB'(i) + CB'(1)) < nn) ? VB'(CB'(i) + CB'(1)) : '0;
  endfunction

  // Vertex a precedes b when x is less, or x equal and y less.
  function automatic logic vless(input logic signed [COORD_BITS-1:0] ax,
                                 input logic signed [COORD_BITS-1:0] ay,
                                 input logic signed [COORD_BITS-1:0] bx,
                                 input logic signed [COORD_BITS-1:0] by);
    vless = (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  // Fetch slots: edge a = {0: a, 1: succ a}, edge b = {2: b, 3: succ b}.
  logic a_fl, b_fl;
  logic [2:0] al_s, ar_s, bl_s, br_s;
  assign a_fl = vless(fx[0], fy[0], fx[1], fy[1]);
  assign b_fl = vless(fx[2], fy[2], fx[3], fy[3]);
  assign al_s = a_fl ? 3'd0 : 3'd1;
  assign ar_s = a_fl ? 3'd1 : 3'd0;
  assign bl_s = b_fl ? 3'd2 : 3'd3;
  assign br_s = b_fl ? 3'd3 : 3'd2;

  // Event point slots for ev_before: v uses 0/1, w uses 2/3.
  logic [2:0] vp_s, wp_s;
  logic       v_left, w_left;
  assign vp_s   = sv_ev[0] ? 3'd1 : 3'd0;
  assign wp_s   = sw_ev[0] ? 3'd3 : 3'd2;
  assign v_left = sv_ev[0] ? !a_fl : a_fl;
  assign w_left = sw_ev[0] ? !b_fl : b_fl;

  logic evb_res;
  always_comb begin
    if (vless(fx[vp_s], fy[vp_s], fx[wp_s], fy[wp_s])) begin
      evb_res = 1'b1;
    end else if (vless(fx[wp_s], fy[wp_s], fx[vp_s], fy[vp_s])) begin
      evb_res = 1'b0;
    end else if (v_left != w_left) begin
      evb_res = v_left;
    end else begin
      evb_res = sv_ev < sw_ev;
    end
  end

  logic [VB-1:0] ea, eb;
  logic          adj;
  logic          shared_l;
  assign adj      = (succ_f(ea, n) == eb) || (ea == succ_f(eb, n));
  assign shared_l = (a_fl ? fidx[0] : fidx[1]) == (b_fl ? fidx[2] : fidx[3]);

  assign busy      = (state != S_IDLE);
  assign vx_wd     = vertex_x;
  assign vy_wd     = vertex_y;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      vcount    <= '0;
      ovf       <= 1'b0;
      done      <= 1'b0;
      cx_ctl    <= '0;
      acount    <= '0;
    end else begin
      done   <= 1'b0;
      cx_ctl <= '0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (vcount < CB'(MAX_VERTICES)) begin
              vcount <= vcount + CB'(1);
            end
            if (last_vertex) begin
              if (ovf || !(vcount < CB'(MAX_VERTICES))) begin
                is_simple <= 1'b0;
                overflow  <= 1'b1;
                done      <= 1'b1;
                vcount    <= '0;
                ovf       <= 1'b0;
              end else begin
                n     <= vcount + CB'(1);
                ne    <= NB'(2 * (int'(vcount) + 1));
                si    <= '0;
                state <= S_SI;
              end
            end else if (!(vcount < CB'(MAX_VERTICES))) begin
              ovf <= 1'b1;
            end
          end
        end
        // Insertion sort over event numbers.
        S_SI: begin
          if (si == ne) begin
            si     <= '0;
            acount <= '0;
            state  <= S_WI;
          end else begin
            sv_ev <= EB'(si);
            sj    <= si;
            state <= S_SJ;
          end
        end
        S_SJ: begin
          if (sj == '0) begin
            state <= S_SPUT;
          end else begin
            state <= S_SJW;
          end
        end
        S_SJW: begin
          state <= S_EVB;
        end
        S_EVB: begin
          sw_ev     <= eo_rd;
          fidx[0]   <= sv_ev[EB-1:1];
          fidx[1]   <= succ_f(sv_ev[EB-1:1], n);
          fidx[2]   <= eo_rd[EB-1:1];
          fidx[3]   <= succ_f(eo_rd[EB-1:1], n);
          op        <= OP_EVB;
          fptr      <= '0;
          ret_state <= S_EVB;
          state     <= S_FETCH;
          if (ret_state == S_EVB) begin
            // Returned from evaluation.
            ret_state <= S_IDLE;
            if (res_bool) begin
              sj    <= sj - NB'(1);
              state <= S_SJ;
            end else begin
              state <= S_SPUT;
            end
          end
        end
        S_SPUT: begin
          si    <= si + NB'(1);
          state <= S_SI;
        end
        // Sweep over sorted events.
        S_WI: begin
          if (si == ne) begin
            result_simple <= 1'b1;
            state         <= S_DONE;
          end else begin
            state <= S_WIW;
          end
        end
        S_WIW: begin
          state <= S_WEV;
        end
        S_WEV: begin
          if (ret_state != S_WEV) begin
            sv_ev     <= eo_rd;
            cur_e     <= eo_rd[EB-1:1];
            fidx[0]   <= eo_rd[EB-1:1];
            fidx[1]   <= succ_f(eo_rd[EB-1:1], n);
            fidx[2]   <= eo_rd[EB-1:1];
            fidx[3]   <= succ_f(eo_rd[EB-1:1], n);
            op        <= OP_EVB;
            sw_ev     <= eo_rd;
            fptr      <= '0;
            ret_state <= S_WEV;
            state     <= S_FETCH;
          end else begin
            ret_state <= S_IDLE;
            p         <= '0;
            if (v_left) begin
              if (acount >= CB'(MAX_VERTICES)) begin
                si    <= si + NB'(1);
                state <= S_WI;
              end else begin
                state <= S_LP;
              end
            end else begin
              state <= S_RP;
            end
          end
        end
        // Left event: find first entry that the new edge is below.
        S_LP: begin
          state <= (p < acount) ? S_LPW : S_LSH;
          k     <= acount;
        end
        S_LPW: begin
          state <= S_LBL;
        end
        S_LBL: begin
          if (ret_state != S_LBL) begin
            fidx[0]   <= cur_e;
            fidx[1]   <= succ_f(cur_e, n);
            fidx[2]   <= al_rd;
            fidx[3]   <= succ_f(al_rd, n);
            ea        <= cur_e;
            eb        <= al_rd;
            op        <= OP_BLW;
            fptr      <= '0;
            ret_state <= S_LBL;
            state     <= S_FETCH;
          end else begin
            ret_state <= S_IDLE;
            if (res_bool) begin
              k     <= acount;
              state <= S_LSH;
            end else begin
              p     <= p + CB'(1);
              state <= S_LP;
            end
          end
        end
        S_LSH: begin
          state <= (k > p) ? S_LSHW : S_LINS;
        end
        S_LSHW: begin
          k     <= k - CB'(1);
          state <= S_LSH;
        end
        S_LINS: begin
          acount <= acount + CB'(1);
          state  <= S_LN1;
        end
        S_LN1: begin
          state <= (p + CB'(1) < acount) ? S_LN1W : S_LN0;
        end
        S_LN1W: begin
          state <= S_LST1;
        end
        S_LST1: begin
          if (ret_state != S_LST1) begin
            ea        <= cur_e;
            eb        <= al_rd;
            fidx[0]   <= cur_e;
            fidx[1]   <= succ_f(cur_e, n);
            fidx[2]   <= al_rd;
            fidx[3]   <= succ_f(al_rd, n);
            op        <= OP_STR;
            fptr      <= '0;
            ret_state <= S_LST1;
            state     <= S_FETCH;
          end else begin
            ret_state <= S_IDLE;
            if (res_bool) begin
              result_simple <= 1'b0;
              state         <= S_DONE;
            end else begin
              state <= S_LN0;
            end
          end
        end
        S_LN0: begin
          if (p > '0) begin
            state <= S_LN0W;
          end else begin
            si    <= si + NB'(1);
            state <= S_WI;
          end
        end
        S_LN0W: begin
          state <= S_LST0;
        end
        S_LST0: begin
          if (ret_state != S_LST0) begin
            ea        <= cur_e;
            eb        <= al_rd;
            fidx[0]   <= cur_e;
            fidx[1]   <= succ_f(cur_e, n);
            fidx[2]   <= al_rd;
            fidx[3]   <= succ_f(al_rd, n);
            op        <= OP_STR;
            fptr      <= '0;
            ret_state <= S_LST0;
            state     <= S_FETCH;
          end else begin
            ret_state <= S_IDLE;
            if (res_bool) begin
              result_simple <= 1'b0;
              state         <= S_DONE;
            end else begin
              si    <= si + NB'(1);
              state <= S_WI;
            end
          end
        end
        // Right event: locate the edge in the list.
        S_RP: begin
          if (p < acount) begin
            state <= S_RPW;
          end else begin
            si    <= si + NB'(1);
            state <= S_WI;
          end
        end
        S_RPW: begin
          if (al_rd == cur_e) begin
            k <= p;
            if (p > '0 && p + CB'(1) < acount) begin
              state <= S_RA;
            end else begin
              state <= S_RSH;
            end
          end else begin
            p     <= p + CB'(1);
            state <= S_RP;
          end
        end
        S_RA: begin
          state <= S_RAW;
        end
        S_RAW: begin
          nb_a  <= al_rd;
          state <= S_RB;
        end
        S_RB: begin
          state <= S_RBW;
        end
        S_RBW: begin
          nb_b  <= al_rd;
          state <= S_RST;
        end
        S_RST: begin
          if (ret_state != S_RST) begin
            ea        <= nb_a;
            eb        <= nb_b;
            fidx[0]   <= nb_a;
            fidx[1]   <= succ_f(nb_a, n);
            fidx[2]   <= nb_b;
            fidx[3]   <= succ_f(nb_b, n);
            op        <= OP_STR;
            fptr      <= '0;
            ret_state <= S_RST;
            state     <= S_FETCH;
          end else begin
            ret_state <= S_IDLE;
            if (res_bool) begin
              result_simple <= 1'b0;
              state         <= S_DONE;
            end else begin
              state <= S_RSH;
            end
          end
        end
        S_RSH: begin
          if (k + CB'(1) < acount) begin
            state <= S_RSHW;
          end else begin
            acount <= acount - CB'(1);
            si     <= si + NB'(1);
            state  <= S_WI;
          end
        end
        S_RSHW: begin
          k     <= k + CB'(1);
          state <= S_RSH;
        end
        S_DONE: begin
          is_simple <= result_simple;
          overflow  <= 1'b0;
          done      <= 1'b1;
          vcount    <= '0;
          ovf       <= 1'b0;
          acount    <= '0;
          state     <= S_IDLE;
        end
        // Fetch four vertices into the coordinate file.
        S_FETCH: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          state <= S_FGET;
        end
        S_FGET: begin
          fx[fptr] <= vx_rd;
          fy[fptr] <= vy_rd;
          if (fptr == 3'd3) begin
            step  <= '0;
            state <= S_XWAIT;
          end else begin
            fptr  <= fptr + 3'd1;
            state <= S_FETCH;
          end
        end
        // Evaluate the requested predicate, using the shared cross unit for the below and crossing tests.
        S_XWAIT: begin
          case (op)
            OP_EVB: begin
              res_bool <= evb_res;
              state    <= ret_state;
            end
            OP_BLW: begin
              if (shared_l) begin
                res_bool <= fy[ar_s] < fy[br_s];
                state    <= ret_state;
              end else if (step == 3'd0) begin
                cx_a   <= al_s; cx_b <= ar_s; cx_c <= bl_s;
                cx_ctl <= '{start: 1'b1};
                step   <= 3'd1;
              end else if (cx_done) begin
                res_bool <= (cx_sgn == SIGN_POS);
                state    <= ret_state;
              end
            end
            default: begin
              if (adj) begin
                res_bool <= 1'b0;
                state    <= ret_state;
              end else begin
                case (step)
                  3'd0: begin
                    cx_a <= al_s; cx_b <= ar_s; cx_c <= bl_s;
                    cx_ctl <= '{start: 1'b1};
                    step <= 3'd1;
                  end
                  3'd1: begin
                    if (cx_done) begin
                      s0   <= cx_sgn;
                      cx_c <= br_s;
                      cx_ctl <= '{start: 1'b1};
                      step <= 3'd2;
                    end
                  end
                  3'd2: begin
                    if (cx_done) begin
                      if (sign_prod_pos(s0, cx_sgn)) begin
                        res_bool <= 1'b0;
                        state    <= ret_state;
                      end else begin
                        cx_a <= bl_s; cx_b <= br_s; cx_c <= al_s;
                        cx_ctl <= '{start: 1'b1};
                        step <= 3'd3;
                      end
                    end
                  end
                  3'd3: begin
                    if (cx_done) begin
                      s1   <= cx_sgn;
                      cx_c <= ar_s;
                      cx_ctl <= '{start: 1'b1};
                      step <= 3'd4;
                    end
                  end
                  default: begin
                    if (cx_done) begin
                      res_bool <= !sign_prod_pos(s1, cx_sgn);
                      state    <= ret_state;
                    end
                  end
                endcase
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Memory addressing follows the sequencer state.
  always_comb begin
    v_we    = 1'b0;
    v_addr  = fidx[fptr];
    eo_we   = 1'b0;
    eo_addr = EB'(sj - NB'(1));
    eo_wd   = sv_ev;
    al_we   = 1'b0;
    al_addr = p[VB-1:0];
    al_wd   = cur_e;
    case (state)
      S_IDLE: begin
        v_we   = start && (vcount < CB'(MAX_VERTICES));
        v_addr = vcount[VB-1:0];
      end
      S_SPUT: begin
        eo_we   = 1'b1;
        eo_addr = EB'(sj);
      end
      S_SJW, S_EVB: begin
        eo_addr = EB'(sj - NB'(1));
        eo_we   = (state == S_EVB) && (ret_state == S_EVB) && res_bool;
        if (eo_we) begin
          eo_addr = EB'(sj);
          eo_wd   = sw_ev;
        end
      end
      S_WI, S_WIW: begin
        eo_addr = EB'(si);
      end
      S_LSH: begin
        al_addr = VB'(k - CB'(1));
      end
      S_LSHW: begin
        al_we   = 1'b1;
        al_addr = k[VB-1:0];
        al_wd   = al_rd;
      end
      S_LINS: begin
        al_we = 1'b1;
      end
      S_LN1, S_LN1W: begin
        al_addr = VB'(p + CB'(1));
      end
      S_LN0, S_LN0W: begin
        al_addr = VB'(p - CB'(1));
      end
      S_RA, S_RAW: begin
        al_addr = VB'(p + CB'(1));
      end
      S_RB, S_RBW: begin
        al_addr = VB'(p - CB'(1));
      end
      S_RSH: begin
        al_addr = VB'(k + CB'(1));
      end
      S_RSHW: begin
        al_we   = 1'b1;
        al_addr = k[VB-1:0];
        al_wd   = al_rd;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/pss_ram.sv
// Generic single-port RAM with registered read.
module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed word and register the word it held before the write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/pss_cross.sv
// Multi-cycle cross-product sign unit: (p1-p0) x (p2-p0), one product per cycle.
module pss_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pss_pkg::cross_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  output logic                         done,
  output logic [1:0]                   sgn
);
  import pss_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax, ay, bx, by;
  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW:0]   diff;
  logic [1:0]           phase;

  assign diff = {p0[PW-1], p0} - {p1[PW-1], p1};

  // Phase 0 takes differences, phases 1 and 2 one product each, then phase 3 signals done with the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        2'd0: begin
          if (ctl.start) begin
            ax    <= DW'(x1) - DW'(x0);
            ay    <= DW'(y1) - DW'(y0);
            bx    <= DW'(x2) - DW'(x0);
            by    <= DW'(y2) - DW'(y0);
            phase <= 2'd1;
          end
        end
        2'd1: begin
          p0    <= ax * by;
          phase <= 2'd2;
        end
        2'd2: begin
          p1    <= bx * ay;
          phase <= 2'd3;
        end
        default: begin
          done  <= 1'b1;
          phase <= 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    if (diff == '0) begin
      sgn = SIGN_ZERO;
    end else if (diff[PW]) begin
      sgn = SIGN_NEG;
    end else begin
      sgn = SIGN_POS;
    end
  end

endmodule

>>> sv/pss_checker.sv
// Port-level checker for the polygon simplicity sweep, bound to the top level.
module pss_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_vertex,
  input logic done,
  input logic is_simple,
  input logic overflow
);

  // An overflow result never claims a simple polygon.
  a_ovf_not_simple: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> !is_simple)
    else $error("overflow result reports simple");

  // A vertex without the last mark never produces a result next cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_vertex |=> !done)
    else $error("result without a closing vertex");

  // Results are single-cycle strobes.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // After a result the block is ready again.
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy with a result shown");

endmodule

bind polygon_simplicity_sweep pss_checker u_pss_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_vertex(last_vertex),
  .done(done), .is_simple(is_simple), .overflow(overflow)
);

>>> test/tb_polygon_simplicity_sweep.sv
// Testbench for polygon_simplicity_sweep: directed table, random polygons, scoreboard.
`timescale 1ns / 1ps

module tb_polygon_simplicity_sweep;

  localparam int NumVert   = pss_pkg::MaxVerticesDefault;
  localparam int CoordW    = pss_pkg::CoordBitsDefault;
  localparam int CycleLimit = 20_000_000;
  localparam int RandomItems = 470;

  typedef struct {
    int x;
    int y;
    bit last;
    bit typed;
    bit want_simple;
    bit want_ovf;
  } vertex_row_t;

  typedef struct {
    bit simple;
    bit ovf;
  } verdict_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic last_vertex;
  logic done;
  logic is_simple;
  logic overflow;

  // Shadow of the loaded polygon.
  int shadow_x[NumVert];
  int shadow_y[NumVert];
  int shadow_count;
  bit shadow_ovf;

  verdict_t verdict_q[$];
  int error_count;
  int cycle_count;
  bit idle_enable;

  polygon_simplicity_sweep u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
    .done(done), .is_simple(is_simple), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Geometry helpers over the shadow polygon.
  function automatic int next_vtx(int i, int n);
    return (i + 1 < n) ? i + 1 : 0;
  endfunction

  function automatic int vtx_order(int a, int b);
    if (shadow_x[a] > shadow_x[b]) return 1;
    if (shadow_x[a] < shadow_x[b]) return -1;
    if (shadow_y[a] > shadow_y[b]) return 1;
    if (shadow_y[a] < shadow_y[b]) return -1;
    return 0;
  endfunction

  function automatic void edge_ends(int e, int n, output int lft, output int rgt);
    int nx;
    nx = next_vtx(e, n);
    if (vtx_order(e, nx) < 0) begin
      lft = e;
      rgt = nx;
    end else begin
      lft = nx;
      rgt = e;
    end
  endfunction

  function automatic int turn_sign(int p0, int p1, int p2);
    longint ax, ay, bx, by, c;
    ax = longint'(shadow_x[p1]) - shadow_x[p0];
    ay = longint'(shadow_y[p1]) - shadow_y[p0];
    bx = longint'(shadow_x[p2]) - shadow_x[p0];
    by = longint'(shadow_y[p2]) - shadow_y[p0];
    c = ax * by - bx * ay;
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic bit edge_below(int s, int t, int n);
    int sl, sr, tl, tr;
    edge_ends(s, n, sl, sr);
    edge_ends(t, n, tl, tr);
    if (sl == tl) return shadow_y[sr] < shadow_y[tr];
    return turn_sign(sl, sr, tl) > 0;
  endfunction

  function automatic bit edges_cross(int a, int b, int n);
    int al, ar, bl, br;
    if (next_vtx(a, n) == b || a == next_vtx(b, n)) return 1'b0;
    edge_ends(a, n, al, ar);
    edge_ends(b, n, bl, br);
    if (turn_sign(al, ar, bl) * turn_sign(al, ar, br) > 0) return 1'b0;
    if (turn_sign(bl, br, al) * turn_sign(bl, br, ar) > 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int event_point(int ev, int n);
    return ev[0] ? next_vtx(ev >> 1, n) : (ev >> 1);
  endfunction

  function automatic bit event_is_left(int ev, int n);
    bit first_left;
    first_left = vtx_order(ev >> 1, next_vtx(ev >> 1, n)) < 0;
    return ev[0] ? !first_left : first_left;
  endfunction

  function automatic bit event_earlier(int a, int b, int n);
    int c;
    bit la, lb;
    c = vtx_order(event_point(a, n), event_point(b, n));
    if (c != 0) return c < 0;
    la = event_is_left(a, n);
    lb = event_is_left(b, n);
    if (la != lb) return la;
    return a < b;
  endfunction

  // Sort the endpoint events, then sweep the active edge list.
  function automatic bit polygon_is_simple(int n);
    int order[2*NumVert];
    int active[NumVert];
    int act_n, i, j, k, p, ev, e;
    for (i = 0; i < 2 * n; i++) begin
      j = i;
      while (j > 0 && event_earlier(i, order[j-1], n)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    act_n = 0;
    for (i = 0; i < 2 * n; i++) begin
      ev = order[i];
      e = ev >> 1;
      p = 0;
      if (event_is_left(ev, n)) begin
        if (act_n >= NumVert) continue;
        while (p < act_n && !edge_below(e, active[p], n)) p++;
        for (k = act_n; k > p; k--) active[k] = active[k-1];
        active[p] = e;
        act_n++;
        if (p + 1 < act_n && edges_cross(e, active[p+1], n)) return 1'b0;
        if (p > 0 && edges_cross(e, active[p-1], n)) return 1'b0;
      end else begin
        while (p < act_n && active[p] != e) p++;
        if (p >= act_n) continue;
        if (p > 0 && p + 1 < act_n && edges_cross(active[p+1], active[p-1], n))
          return 1'b0;
        for (k = p; k + 1 < act_n; k++) active[k] = active[k+1];
        act_n--;
      end
    end
    return 1'b1;
  endfunction

  // Update the shadow for one accepted request and queue any verdict.
  function automatic void absorb_vertex(vertex_row_t r);
    verdict_t v;
    if (shadow_count < NumVert) begin
      shadow_x[shadow_count] = r.x;
      shadow_y[shadow_count] = r.y;
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (!r.last) return;
    v.ovf = shadow_ovf;
    v.simple = shadow_ovf ? 1'b0 : polygon_is_simple(shadow_count);
    if (r.typed) begin
      v.simple = r.want_simple;
      v.ovf = r.want_ovf;
    end
    verdict_q.push_back(v);
    shadow_count = 0;
    shadow_ovf = 1'b0;
  endfunction

  // Drive one request and hold it until the block takes it.
  // Busy is looked at mid-cycle, so the next rising edge is the accepting one.
  task automatic send_vertex(vertex_row_t r);
    if (idle_enable && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    vertex_x <= r.x[CoordW-1:0];
    vertex_y <= r.y[CoordW-1:0];
    last_vertex <= r.last;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    absorb_vertex(r);
  endtask

  task automatic send_point(int x, int y, bit last);
    vertex_row_t r;
    r = '{x, y, last, 1'b0, 1'b0, 1'b0};
    send_vertex(r);
  endtask

  function automatic int rand_coord(bit narrow);
    if (narrow) return int'($urandom_range(16)) - 8;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Compare each verdict with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: is_simple=%0b overflow=%0b", is_simple, overflow);
        error_count++;
      end else begin
        if (is_simple !== verdict_q[0].simple) begin
          $error("is_simple: expected %0b, got %0b", verdict_q[0].simple, is_simple);
          error_count++;
        end
        if (overflow !== verdict_q[0].ovf) begin
          $error("overflow: expected %0b, got %0b", verdict_q[0].ovf, overflow);
          error_count++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    vertex_row_t directed[$];
    int items, n, i, wait_cycles;
    bit narrow;
    bit paused;

    error_count = 0;
    cycle_count = 0;
    shadow_count = 0;
    shadow_ovf = 1'b0;
    idle_enable = 1'b1;
    paused = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    vertex_x = '0;
    vertex_y = '0;
    last_vertex = 1'b0;

    // Directed polygons; typed verdicts where they are obvious.
    directed = '{
      // Triangle over the coordinate extremes.
      '{-32768, -32768, 0, 0, 0, 0},
      '{ 32767, -32768, 0, 0, 0, 0},
      '{     0,  32767, 1, 1, 1, 0},
      // A single vertex and a pair: every edge pair is consecutive.
      '{ 32767,  32767, 1, 1, 1, 0},
      '{-1, -1, 0, 0, 0, 0},
      '{ 1, 1, 1, 1, 1, 0},
      // Bowtie crosses itself.
      '{0, 0, 0, 0, 0, 0},
      '{10, 10, 0, 0, 0, 0},
      '{10, 0, 0, 0, 0, 0},
      '{0, 10, 1, 1, 0, 0},
      // Square.
      '{0, 0, 0, 0, 0, 0},
      '{4, 0, 0, 0, 0, 0},
      '{4, 4, 0, 0, 0, 0},
      '{0, 4, 1, 1, 1, 0},
      // Collinear fold back and a repeated vertex: equal events and shared ends.
      '{0, 0, 0, 0, 0, 0},
      '{2, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0},
      '{3, 0, 1, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{5, 5, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{5, -5, 0, 0, 0, 0},
      '{-5, 0, 1, 0, 0, 0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_vertex(directed[k]);

    // Too many vertices: drop past capacity and report overflow.
    for (i = 0; i < NumVert + 2; i++)
      send_point(rand_coord(1'b0), rand_coord(1'b0), 1'b0);
    send_point(7, 7, 1'b1);

    // Random polygons, mostly small, on a tight grid or the full range.
    items = 0;
    while (items < RandomItems) begin
      idle_enable = !(items > 300 && items < 450);
      if (items > 200 && !paused) begin
        // Hold off until every verdict is back.
        paused = 1'b1;
        start <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
      end
      n = ($urandom_range(19) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
      narrow = $urandom_range(2) != 0;
      for (i = 0; i < n; i++) begin
        // Each vertex takes both coordinates from the chosen field.
        send_point(rand_coord(narrow), rand_coord(narrow), i == n - 1);
        items++;
      end
    end

    start <= 1'b0;
    last_vertex <= 1'b0;
    wait_cycles = 0;
    while (verdict_q.size() != 0 && wait_cycles < 5_000_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);

    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> polygon_simplicity_sweep.f
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pss_cross.sv
sv/polygon_simplicity_sweep.sv
sv/pss_checker.sv
test/tb_polygon_simplicity_sweep.sv
